// File: design/atrp_pkg.sv
// ----------------------------------------------------------------------------
// atrp_pkg
// shared constants, types and the arctangent table for the tilt angle block
// ----------------------------------------------------------------------------
`default_nettype none

package atrp_pkg;

	localparam int SAMPLE_BITS_DEF   = 16;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_LEN          = 24;

	// cordic datapath widths
	localparam int CW        = 33;
	localparam int ZW        = 35;
	localparam int FRAC_BITS = 30;
	localparam int RND_SHIFT = 17;

	localparam logic signed [ZW-1:0] PI_Q30 = 35'sd3373259426;

	localparam int ROLL_W      = 16;
	localparam int PITCH_W     = 15;
	localparam int OUT_W       = ((ROLL_W + PITCH_W + 7) / 8) * 8;
	localparam int ROLL_LIMIT  = 25736;
	localparam int PITCH_LIMIT = 12868;

	// configuration
	localparam int MU_W   = 17;
	localparam int CFG_AW = 1;
	localparam logic [MU_W-1:0] MU_RESET = 17'd655;

	typedef enum logic [CFG_AW-1:0] {
		REG_ROLL_MODE = 1'b0,
		REG_MU_GAIN   = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		BASE_NONE  = 2'd0,
		BASE_PLUS  = 2'd1,
		BASE_MINUS = 2'd2
	} base_t;

	typedef struct packed {
		logic  zero;
		logic  neg_a;
		base_t base;
	} flags_t;

	function automatic logic [31:0] atan_q30(input int idx);
		logic [31:0] v;
		unique case (idx)
			0:       v = 32'h3243F6A8;
			1:       v = 32'h1DAC6705;
			2:       v = 32'h0FADBAFC;
			3:       v = 32'h07F56EA6;
			4:       v = 32'h03FEAB76;
			5:       v = 32'h01FFD55B;
			6:       v = 32'h00FFFAAA;
			7:       v = 32'h007FFF55;
			8:       v = 32'h003FFFEA;
			9:       v = 32'h001FFFFD;
			10:      v = 32'h000FFFFF;
			11:      v = 32'h0007FFFF;
			12:      v = 32'h0003FFFF;
			13:      v = 32'h0001FFFF;
			14:      v = 32'h0000FFFF;
			15:      v = 32'h00007FFF;
			16:      v = 32'h00003FFF;
			17:      v = 32'h00001FFF;
			18:      v = 32'h00000FFF;
			19:      v = 32'h000007FF;
			20:      v = 32'h000003FF;
			21:      v = 32'h000001FF;
			22:      v = 32'h000000FF;
			23:      v = 32'h0000007F;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// File: design/accel_tilt_roll_pitch.sv
// ----------------------------------------------------------------------------
// accel_tilt_roll_pitch
// roll and pitch tilt angles from one three-axis accelerometer sample
// ----------------------------------------------------------------------------
// pipeline: square and radicand registers, square root rows, fold register,
//           normalizer row, cordic row and output rounding register
// throughput: one sample per cycle; the square root and cordic rows advance
//             together and hold as a whole while the output beat is not taken
// reset: clears all valid bits, roll_mode to 0 and mu_gain to 655
// ----------------------------------------------------------------------------
`default_nettype none

module accel_tilt_roll_pitch #(
	parameter int SAMPLE_BITS   = atrp_pkg::SAMPLE_BITS_DEF,
	parameter int CORDIC_STAGES = atrp_pkg::CORDIC_STAGES_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// accel_x, accel_y, accel_z
	input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// roll_angle, pitch_angle
	output logic [atrp_pkg::OUT_W-1:0]              m_tdata,
	input  logic                                    cfg_we,
	input  logic [atrp_pkg::CFG_AW-1:0]             cfg_addr,
	input  logic [atrp_pkg::MU_W-1:0]               cfg_wdata
);

	import atrp_pkg::*;

	localparam int SB  = SAMPLE_BITS;
	localparam int SQW = 2 * SB - 1;
	localparam int MXW = SQW + MU_W;
	localparam int RW  = 2 * SB + 16;
	localparam int RB  = SB + 8;
	localparam int AW  = SB + 9;
	localparam int NW  = (AW > FRAC_BITS) ? AW : FRAC_BITS;
	localparam int TWR = 1 + 2 * SB;

	// configuration registers
	logic            roll_mode_q;
	logic [MU_W-1:0] mu_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_mode_q <= 1'b0;
			mu_q        <= MU_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_ROLL_MODE: roll_mode_q <= cfg_wdata[0];
				REG_MU_GAIN:   mu_q        <= cfg_wdata;
				default:       ;
			endcase
		end
	end

	logic en;
	logic acc;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign acc      = s_tvalid && en;

	// squares
	logic signed [SB-1:0]   x_in;
	logic signed [SB-1:0]   y_in;
	logic signed [SB-1:0]   z_in;
	logic signed [2*SB-1:0] xx;
	logic signed [2*SB-1:0] yy;
	logic signed [2*SB-1:0] zz;

	assign x_in = $signed(s_tdata[SB-1:0]);
	assign y_in = $signed(s_tdata[2*SB-1:SB]);
	assign z_in = $signed(s_tdata[3*SB-1:2*SB]);
	assign xx   = x_in * x_in;
	assign yy   = y_in * y_in;
	assign zz   = z_in * z_in;

	logic                 v_s1, v_s2, v_s3;
	logic signed [SB-1:0] x_s1, y_s1, z_s1;
	logic signed [SB-1:0] x_s2, y_s2, z_s2;
	logic signed [SB-1:0] x_s3, y_s3, z_s3;
	logic                 mode_s1, mode_s2, mode_s3;
	logic [SQW-1:0]       x2_s1, y2_s1, z2_s1, z2_s2;
	logic [MXW-1:0]       mx_s2;
	logic [RW-1:0]        prad_s2, prad_s3, rrad_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= x_in;
			y_s1    <= y_in;
			z_s1    <= z_in;
			mode_s1 <= roll_mode_q;
			x2_s1   <= SQW'(xx);
			y2_s1   <= SQW'(yy);
			z2_s1   <= SQW'(zz);

			x_s2    <= x_s1;
			y_s2    <= y_s1;
			z_s2    <= z_s1;
			mode_s2 <= mode_s1;
			z2_s2   <= z2_s1;
			mx_s2   <= MXW'(mu_q) * MXW'(x2_s1);
			prad_s2 <= (RW'(y2_s1) + RW'(z2_s1)) << 16;

			x_s3    <= x_s2;
			y_s3    <= y_s2;
			z_s3    <= z_s2;
			mode_s3 <= mode_s2;
			prad_s3 <= prad_s2;
			rrad_s3 <= RW'(mx_s2) + (RW'(z2_s2) << 16);
		end
	end

	// square root rows
	logic [RW-1:0]  rrem  [0:RB];
	logic [RB-1:0]  rroot [0:RB];
	logic [TWR-1:0] rtag  [0:RB];
	logic           rv    [0:RB];
	logic [RW-1:0]  prem  [0:RB];
	logic [RB-1:0]  proot [0:RB];
	logic [SB-1:0]  ptag  [0:RB];
	logic           pv    [0:RB];

	assign rrem[0]  = rrad_s3;
	assign rroot[0] = '0;
	assign rtag[0]  = {mode_s3, y_s3, z_s3};
	assign rv[0]    = v_s3;
	assign prem[0]  = prad_s3;
	assign proot[0] = '0;
	assign ptag[0]  = x_s3;
	assign pv[0]    = v_s3;

	genvar k;
	generate
		for (k = 0; k < RB; k++) begin : g_sqrt
			atrp_sqrt_cell #(
				.RW  (RW),
				.RB  (RB),
				.BIT (RB - 1 - k),
				.TW  (TWR)
			) u_roll_sq (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (en),
				.vin     (rv[k]),
				.rem_in  (rrem[k]),
				.root_in (rroot[k]),
				.tag_in  (rtag[k]),
				.v_q     (rv[k+1]),
				.rem_q   (rrem[k+1]),
				.root_q  (rroot[k+1]),
				.tag_q   (rtag[k+1])
			);

			atrp_sqrt_cell #(
				.RW  (RW),
				.RB  (RB),
				.BIT (RB - 1 - k),
				.TW  (SB)
			) u_pitch_sq (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (en),
				.vin     (pv[k]),
				.rem_in  (prem[k]),
				.root_in (proot[k]),
				.tag_in  (ptag[k]),
				.v_q     (pv[k+1]),
				.rem_q   (prem[k+1]),
				.root_q  (proot[k+1]),
				.tag_q   (ptag[k+1])
			);
		end
	endgenerate

	// atan2 arguments
	logic                 mode_r;
	logic signed [SB-1:0] y_r;
	logic signed [SB-1:0] z_r;
	logic signed [SB-1:0] x_r;
	logic signed [AW-1:0] rmag;
	logic signed [AW-1:0] roll_a;
	logic signed [AW-1:0] roll_b;
	logic signed [AW-1:0] pitch_a;
	logic signed [AW-1:0] pitch_b;

	assign mode_r  = rtag[RB][TWR-1];
	assign y_r     = $signed(rtag[RB][2*SB-1:SB]);
	assign z_r     = $signed(rtag[RB][SB-1:0]);
	assign x_r     = $signed(ptag[RB]);
	assign rmag    = $signed(AW'(rroot[RB]));
	assign pitch_a = -(AW'(x_r) <<< 8);
	assign pitch_b = $signed(AW'(proot[RB]));

	always_comb begin
		if (mode_r) begin
			roll_a = AW'(y_r) <<< 8;
			roll_b = z_r[SB-1] ? -rmag : rmag;
		end else begin
			roll_a = AW'(y_r);
			roll_b = AW'(z_r);
		end
	end

	logic                      roll_v;
	logic                      pitch_v;
	logic signed [ROLL_W-1:0]  roll_ang;
	logic signed [PITCH_W-1:0] pitch_ang;

	atrp_atan2 #(
		.AW     (AW),
		.NW     (NW),
		.STAGES (CORDIC_STAGES),
		.OW     (ROLL_W),
		.LIMIT  (ROLL_LIMIT)
	) u_roll (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vin    (rv[RB]),
		.a      (roll_a),
		.b      (roll_b),
		.v_q    (roll_v),
		.ang_q  (roll_ang)
	);

	atrp_atan2 #(
		.AW     (AW),
		.NW     (NW),
		.STAGES (CORDIC_STAGES),
		.OW     (PITCH_W),
		.LIMIT  (PITCH_LIMIT)
	) u_pitch (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vin    (pv[RB]),
		.a      (pitch_a),
		.b      (pitch_b),
		.v_q    (pitch_v),
		.ang_q  (pitch_ang)
	);

	assign m_tvalid = roll_v;
	assign m_tdata  = OUT_W'({pitch_ang, roll_ang});

	// lanes in lockstep and angles in range
	a_sqrt_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		rv[RB] == pv[RB])
		else $error("square root rows out of step");

	a_lane_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		roll_v == pitch_v)
		else $error("atan2 lanes out of step");

	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (roll_ang <= ROLL_LIMIT) && (roll_ang >= -ROLL_LIMIT))
		else $error("roll angle out of range");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (pitch_ang <= PITCH_LIMIT) && (pitch_ang >= -PITCH_LIMIT))
		else $error("pitch angle out of range");

endmodule

`default_nettype wire

// File: design/atrp_sqrt_cell.sv
// ----------------------------------------------------------------------------
// atrp_sqrt_cell
// one digit of a pipelined integer square root, with a side tag carried along
// ----------------------------------------------------------------------------
`default_nettype none

module atrp_sqrt_cell #(
	parameter int RW  = 48,
	parameter int RB  = 24,
	parameter int BIT = 0,
	parameter int TW  = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vin,
	input  logic [RW-1:0] rem_in,
	input  logic [RB-1:0] root_in,
	input  logic [TW-1:0] tag_in,
	output logic          v_q,
	output logic [RW-1:0] rem_q,
	output logic [RB-1:0] root_q,
	output logic [TW-1:0] tag_q
);

	logic [RW:0]   trial;
	logic [RW:0]   rem_x;
	logic          take;
	logic [RB-1:0] root_nx;

	assign trial = ((RW+1)'(root_in) << (BIT + 1)) | ((RW+1)'(1) << (2 * BIT));
	assign rem_x = {1'b0, rem_in};
	assign take  = (rem_x >= trial);

	always_comb begin
		root_nx      = root_in;
		root_nx[BIT] = take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= take ? RW'(rem_x - trial) : rem_in;
			root_q <= root_nx;
			tag_q  <= tag_in;
		end
	end

endmodule

`default_nettype wire

// File: design/atrp_norm_cell.sv
// ----------------------------------------------------------------------------
// atrp_norm_cell
// one step of the magnitude normalizer: shift both left when the top is clear
// ----------------------------------------------------------------------------
`default_nettype none

module atrp_norm_cell #(
	parameter int NW = 30,
	parameter int SH = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vin,
	input  logic [NW-1:0]   ma_in,
	input  logic [NW-1:0]   mb_in,
	input  atrp_pkg::flags_t fl_in,
	output logic            v_q,
	output logic [NW-1:0]   ma_q,
	output logic [NW-1:0]   mb_q,
	output atrp_pkg::flags_t fl_q
);

	import atrp_pkg::*;

	logic [NW-1:0] mor;
	logic          shift;

	assign mor   = ma_in | mb_in;
	assign shift = ~|mor[NW-1 -: SH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_q <= shift ? (ma_in << SH) : ma_in;
			mb_q <= shift ? (mb_in << SH) : mb_in;
			fl_q <= fl_in;
		end
	end

endmodule

`default_nettype wire

// File: design/atrp_cordic_cell.sv
// ----------------------------------------------------------------------------
// atrp_cordic_cell
// one vectoring rotation toward the x axis, accumulating the angle in q5.30
// ----------------------------------------------------------------------------
`default_nettype none

module atrp_cordic_cell #(
	parameter int STAGE = 0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           vin,
	input  logic signed [atrp_pkg::CW-1:0] x_in,
	input  logic signed [atrp_pkg::CW-1:0] y_in,
	input  logic signed [atrp_pkg::ZW-1:0] z_in,
	input  atrp_pkg::flags_t               fl_in,
	output logic                           v_q,
	output logic signed [atrp_pkg::CW-1:0] x_q,
	output logic signed [atrp_pkg::CW-1:0] y_q,
	output logic signed [atrp_pkg::ZW-1:0] z_q,
	output atrp_pkg::flags_t               fl_q
);

	import atrp_pkg::*;

	localparam logic signed [ZW-1:0] ATAN = ZW'(atan_q30(STAGE));

	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;
	logic                 y_pos;
	logic                 y_neg;

	assign xs    = x_in >>> STAGE;
	assign ys    = y_in >>> STAGE;
	assign y_neg = y_in[CW-1];
	assign y_pos = !y_in[CW-1] && (y_in != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fl_q <= fl_in;
			priority if (y_pos) begin
				x_q <= x_in + ys;
				y_q <= y_in - xs;
				z_q <= z_in + ATAN;
			end else if (y_neg) begin
				x_q <= x_in - ys;
				y_q <= y_in + xs;
				z_q <= z_in - ATAN;
			end else begin
				x_q <= x_in;
				y_q <= y_in;
				z_q <= z_in;
			end
		end
	end

endmodule

`default_nettype wire

// File: design/atrp_atan2.sv
// ----------------------------------------------------------------------------
// atrp_atan2
// pipelined atan2 lane: quadrant fold, normalizer row, cordic row, rounding
// ----------------------------------------------------------------------------
`default_nettype none

module atrp_atan2 #(
	parameter int AW     = 25,
	parameter int NW     = 30,
	parameter int STAGES = 16,
	parameter int OW     = 16,
	parameter int LIMIT  = 25736
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vin,
	input  logic signed [AW-1:0] a,
	input  logic signed [AW-1:0] b,
	output logic                 v_q,
	output logic signed [OW-1:0] ang_q
);

	import atrp_pkg::*;

	localparam int NS = $clog2(NW);
	localparam logic signed [ZW-1:0] LIM = ZW'(LIMIT);

	// quadrant fold
	logic          a_neg;
	logic          a_pos;
	logic          b_neg;
	logic [AW-1:0] a_abs;
	logic [AW-1:0] b_abs;
	flags_t        fl_c;

	assign a_neg = a[AW-1];
	assign a_pos = !a[AW-1] && (a != '0);
	assign b_neg = b[AW-1];
	assign a_abs = a_neg ? AW'(-a) : AW'(a);
	assign b_abs = b_neg ? AW'(-b) : AW'(b);

	always_comb begin
		fl_c.zero  = (a == '0) && (b == '0);
		fl_c.neg_a = b_neg ? a_pos : a_neg;
		fl_c.base  = b_neg ? (a_neg ? BASE_MINUS : BASE_PLUS) : BASE_NONE;
	end

	logic [NW-1:0] ma_n [0:NS];
	logic [NW-1:0] mb_n [0:NS];
	flags_t        fl_n [0:NS];
	logic          v_n  [0:NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_n[0] <= 1'b0;
		end else if (en) begin
			v_n[0] <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_n[0] <= NW'(a_abs);
			mb_n[0] <= NW'(b_abs);
			fl_n[0] <= fl_c;
		end
	end

	genvar k;
	generate
		for (k = 0; k < NS; k++) begin : g_norm
			atrp_norm_cell #(
				.NW (NW),
				.SH (1 << (NS - 1 - k))
			) u_norm (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (en),
				.vin    (v_n[k]),
				.ma_in  (ma_n[k]),
				.mb_in  (mb_n[k]),
				.fl_in  (fl_n[k]),
				.v_q    (v_n[k+1]),
				.ma_q   (ma_n[k+1]),
				.mb_q   (mb_n[k+1]),
				.fl_q   (fl_n[k+1])
			);
		end
	endgenerate

	// cordic row
	logic signed [CW-1:0] x_c  [0:STAGES];
	logic signed [CW-1:0] y_c  [0:STAGES];
	logic signed [ZW-1:0] z_c  [0:STAGES];
	flags_t               fl_r [0:STAGES];
	logic                 v_c  [0:STAGES];
	logic signed [CW-1:0] y_mag;

	assign x_c[0]  = $signed(CW'(mb_n[NS][NW-1 -: FRAC_BITS]));
	assign y_mag   = $signed(CW'(ma_n[NS][NW-1 -: FRAC_BITS]));
	assign y_c[0]  = fl_n[NS].neg_a ? -y_mag : y_mag;
	assign fl_r[0] = fl_n[NS];
	assign v_c[0]  = v_n[NS];

	always_comb begin
		unique case (fl_n[NS].base)
			BASE_PLUS:  z_c[0] = PI_Q30;
			BASE_MINUS: z_c[0] = -PI_Q30;
			default:    z_c[0] = '0;
		endcase
	end

	genvar s;
	generate
		for (s = 0; s < STAGES; s++) begin : g_cordic
			atrp_cordic_cell #(
				.STAGE (s)
			) u_rot (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (en),
				.vin    (v_c[s]),
				.x_in   (x_c[s]),
				.y_in   (y_c[s]),
				.z_in   (z_c[s]),
				.fl_in  (fl_r[s]),
				.v_q    (v_c[s+1]),
				.x_q    (x_c[s+1]),
				.y_q    (y_c[s+1]),
				.z_q    (z_c[s+1]),
				.fl_q   (fl_r[s+1])
			);
		end
	endgenerate

	// round to 13 fractional bits (q3.13 for the roll lane) and clamp
	logic signed [ZW-1:0] z_rnd;
	logic signed [ZW-1:0] z_sh;
	logic signed [ZW-1:0] z_clamp;

	assign z_rnd = z_c[STAGES] + (ZW'(1) <<< (RND_SHIFT - 1));
	assign z_sh  = z_rnd >>> RND_SHIFT;

	always_comb begin
		priority if (fl_r[STAGES].zero) begin
			z_clamp = '0;
		end else if (z_sh > LIM) begin
			z_clamp = LIM;
		end else if (z_sh < -LIM) begin
			z_clamp = -LIM;
		end else begin
			z_clamp = z_sh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_c[STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_q <= OW'(z_clamp);
		end
	end

endmodule

`default_nettype wire
